>>> design/fcrc_pkg.sv
// Shared types and constants for the fractional clock ratio converter.
package fcrc_pkg;

  // Field and register widths.
  localparam int unsigned NUM_W  = 32;
  localparam int unsigned DEN_W  = 40;
  localparam int unsigned ELAP_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned DIVD_W = 65;
  localparam int unsigned QUO_W  = 64;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned ADDR_W = 4;

  // Reset values and the fallback ratio used when a ratio register is zero.
  localparam logic [NUM_W-1:0] NUM_RESET   = NUM_W'(1);
  localparam logic [DEN_W-1:0] DEN_RESET   = DEN_W'(4);
  localparam logic [NUM_W-1:0] NUM_DEFAULT = NUM_W'(1);
  localparam logic [DEN_W-1:0] DEN_DEFAULT = DEN_W'(4);

  // Last iteration of the divider: one step per dividend bit.
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIVD_W - 1);

  // Register index, taken from address bit 3 (registers sit 8 bytes apart).
  typedef enum logic {
    REG_NUMERATOR   = 1'b0,
    REG_DENOMINATOR = 1'b1
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

>>> design/fractional_clock_ratio_converter.sv
// Each accepted item passes through the multiply, add, 65 divide steps and the
// hand-off, which waits until the output register is free, before its result is on
// out_valid; a new item is taken only in idle, after the hand-off. The restoring
// divider retires one of the 65 dividend bits per cycle. A finished result waits in
// the output register while the next item is accepted. Reset (rst_n low, synchronous)
// restores numerator 1, denominator 4, clears the carried fraction and empties the output register.
module fractional_clock_ratio_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fcrc_pkg::ELAP_W-1:0]   in_elapsed_clocks,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fcrc_pkg::QUO_W-1:0]    out_timer_clocks,
  output logic                          out_tick_issued,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcrc_pkg::ADDR_W-1:0]   paddr,
  input  logic [fcrc_pkg::DATA_W-1:0]   pwdata,
  output logic [fcrc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import fcrc_pkg::*;

  // Configuration and carried state.
  logic [NUM_W-1:0]  ratio_num_r;
  logic [DEN_W-1:0]  ratio_den_r;
  logic [DEN_W-1:0]  fraction_r;

  // Sequencer and datapath registers.
  state_t             state_r, state_nxt;
  logic [ELAP_W-1:0]  elapsed_r;
  logic [NUM_W-1:0]   num_eff_r;
  logic [DEN_W-1:0]   den_eff_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DIVD_W-1:0]  div_r;
  logic [DEN_W-1:0]   rem_r;
  logic [CNT_W-1:0]   cnt_r;

  // Output register.
  logic               out_valid_r;
  logic [QUO_W-1:0]   out_quo_r;
  logic               out_tick_r;

  // Control decoded from the state.
  logic in_take;
  logic cfg_wr;
  logic out_free;
  logic div_end;
  logic out_load;

  // Shared divider step and helpers.
  logic [DEN_W:0]     rem_sh;
  logic [DEN_W:0]     rem_diff;
  logic               q_bit;
  logic [DIVD_W-1:0]  sum_full;
  logic [QUO_W-1:0]   quo_sat;
  logic               use_default;
  reg_idx_t           wr_idx;

  assign cfg_wr      = psel && penable && pwrite;
  assign wr_idx      = reg_idx_t'(paddr[3]);
  assign use_default = (ratio_num_r == '0) || (ratio_den_r == '0);
  assign out_free    = !out_valid_r || out_ready;
  assign div_end     = (cnt_r == DIV_LAST);

  // One restoring divide step: shift in the next dividend bit, try a subtract.
  assign rem_sh   = {rem_r, div_r[DIVD_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_eff_r};
  assign q_bit    = (rem_sh >= {1'b0, den_eff_r});

  // Dividend: product plus the carried fraction, kept to 65 bits.
  assign sum_full = {1'b0, prod_r} + {{(DIVD_W-DEN_W){1'b0}}, fraction_r};

  // A quotient needing a 65th bit saturates.
  assign quo_sat = div_r[DIVD_W-1] ? '1 : div_r[QUO_W-1:0];

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_DIV;
      ST_DIV:  if (div_end) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_DONE: out_load = out_free;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign in_take = in_valid && in_ready;

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Ratio registers and carried fraction; a ratio write clears the fraction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_num_r <= NUM_RESET;
      ratio_den_r <= DEN_RESET;
      fraction_r  <= '0;
    end else if (cfg_wr) begin
      fraction_r <= '0;
      unique case (wr_idx)
        REG_NUMERATOR:   ratio_num_r <= pwdata[NUM_W-1:0];
        REG_DENOMINATOR: ratio_den_r <= pwdata[DEN_W-1:0];
        default:         ratio_num_r <= ratio_num_r;
      endcase
    end else if (state_r == ST_DIV && div_end) begin
      fraction_r <= q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  // Datapath: latch operands, multiply, add, then iterate the divider.
  always_ff @(posedge clk) begin
    if (in_take) begin
      elapsed_r <= in_elapsed_clocks;
      num_eff_r <= use_default ? NUM_DEFAULT : ratio_num_r;
      den_eff_r <= use_default ? DEN_DEFAULT : ratio_den_r;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(elapsed_r) * PROD_W'(num_eff_r);
    end
    if (state_r == ST_ADD) begin
      div_r <= sum_full;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (state_r == ST_DIV) begin
      div_r <= {div_r[DIVD_W-2:0], q_bit};
      rem_r <= q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Output register holds the result until it is taken.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_quo_r  <= quo_sat;
      out_tick_r <= (quo_sat != '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_timer_clocks = out_quo_r;
  assign out_tick_issued  = out_tick_r;

  // Register read-back and an always-ready bus.
  always_comb begin
    unique case (reg_idx_t'(paddr[3]))
      REG_NUMERATOR:   prdata = DATA_W'(ratio_num_r);
      REG_DENOMINATOR: prdata = DATA_W'(ratio_den_r);
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the fractional clock ratio converter.
module testbench;

  import fcrc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned RANDOM_PHASES = 14;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned DRAIN_CYCLES = 80;

  // One expected batch result.
  typedef struct {
    logic [QUO_W-1:0] timer_clocks;
    logic             tick_issued;
  } batch_result_t;

  // Keeps its own copy of the ratio registers and the carried fraction, and
  // queues the timer clocks that each accepted batch should produce.
  class ratio_scoreboard;
    logic [NUM_W-1:0] numerator;
    logic [DEN_W-1:0] denominator;
    logic [DEN_W-1:0] fraction_left;
    batch_result_t    expected_q[$];
    int unsigned      errors;
    int unsigned      batches;
    int unsigned      results;
    int unsigned      idle_batches;
    int unsigned      wide_dividends;
    int unsigned      ratio_writes;

    function new();
      numerator      = NUM_RESET;
      denominator    = DEN_RESET;
      fraction_left  = '0;
      errors         = 0;
      batches        = 0;
      results        = 0;
      idle_batches   = 0;
      wide_dividends = 0;
      ratio_writes   = 0;
    endfunction

    // A ratio register write drops the upper bits and clears the fraction.
    function void write_ratio(reg_idx_t idx, logic [DATA_W-1:0] value);
      if (idx == REG_NUMERATOR) begin
        numerator = value[NUM_W-1:0];
      end else begin
        denominator = value[DEN_W-1:0];
      end
      fraction_left = '0;
      ratio_writes++;
    endfunction

    // Divides the exact 65-bit dividend and queues the saturated quotient.
    function void note_batch(logic [ELAP_W-1:0] elapsed);
      logic [NUM_W-1:0]  num;
      logic [DEN_W-1:0]  den;
      logic [DIVD_W-1:0] dividend;
      logic [DIVD_W-1:0] quotient;
      logic [DIVD_W-1:0] remainder;
      batch_result_t     res;
      num = numerator;
      den = denominator;
      if (num == '0 || den == '0) begin
        num = NUM_DEFAULT;
        den = DEN_DEFAULT;
      end
      dividend  = DIVD_W'(elapsed) * DIVD_W'(num) + DIVD_W'(fraction_left);
      quotient  = dividend / DIVD_W'(den);
      remainder = dividend % DIVD_W'(den);
      fraction_left = remainder[DEN_W-1:0];
      res.timer_clocks = quotient[DIVD_W-1] ? '1 : quotient[QUO_W-1:0];
      res.tick_issued  = (res.timer_clocks != '0);
      if (dividend[DIVD_W-1]) begin
        wide_dividends++;
      end
      if (!res.tick_issued) begin
        idle_batches++;
      end
      batches++;
      expected_q.push_back(res);
    endfunction

    // Compares one result with the oldest expectation.
    function void check_result(logic [QUO_W-1:0] timer_clocks, logic tick_issued);
      batch_result_t res;
      results++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: timer_clocks %0h, tick_issued %0b", timer_clocks,
               tick_issued);
        errors++;
        return;
      end
      res = expected_q.pop_front();
      if (timer_clocks !== res.timer_clocks) begin
        $error("timer_clocks: expected %0h, got %0h", res.timer_clocks, timer_clocks);
        errors++;
      end
      if (tick_issued !== res.tick_issued) begin
        $error("tick_issued: expected %0b, got %0b", res.tick_issued, tick_issued);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ELAP_W-1:0]   in_elapsed_clocks;
  logic                out_valid;
  logic                out_ready;
  logic [QUO_W-1:0]    out_timer_clocks;
  logic                out_tick_issued;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  ratio_scoreboard     sb;
  int unsigned         send_idle_pct;
  int unsigned         stall_pct;
  int unsigned         stall_burst;
  int unsigned         cycle_count;
  int unsigned         ratio_settings;

  fractional_clock_ratio_converter u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_elapsed_clocks (in_elapsed_clocks),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_timer_clocks  (out_timer_clocks),
    .out_tick_issued   (out_tick_issued),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Clock with a period of 4.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watch both channels at every edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_batch(in_elapsed_clocks);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_timer_clocks, out_tick_issued);
      end
    end
  end

  // Receiver back-pressure: random per cycle, with an occasional long stall.
  always @(posedge clk) begin
    if (stall_burst != 0) begin
      stall_burst <= stall_burst - 1;
      out_ready   <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(63) == 0) begin
      stall_burst <= $urandom_range(90, 1);
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Writes one ratio register through the setup and access phases, then returns
  // the bus to idle.
  task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_ratio(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every batch has produced its result. The first edge lets the
  // monitor note a batch accepted in the current time step.
  task automatic drain_results();
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  // Changes the ratio once the block is idle.
  task automatic set_ratio(input logic [DATA_W-1:0] num_value,
                           input logic [DATA_W-1:0] den_value);
    drain_results();
    apb_write(REG_NUMERATOR, num_value);
    apb_write(REG_DENOMINATOR, den_value);
    ratio_settings++;
  endtask

  // Presents one batch and holds it until accepted.
  task automatic send_batch(input logic [ELAP_W-1:0] elapsed);
    in_valid          <= 1'b1;
    in_elapsed_clocks <= elapsed;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender gap before the next batch: short random gaps, now and then a long one.
  task automatic pace_sender();
    int unsigned gap;
    gap = 0;
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct && gap < 40) begin
        gap++;
      end
      if ($urandom_range(7) == 0) begin
        gap += $urandom_range(80);
      end
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Elapsed counts weighted toward the extremes and small values.
  function automatic logic [ELAP_W-1:0] pick_elapsed();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return ELAP_W'($urandom_range(255));
      4:       return ELAP_W'($urandom_range(65535));
      default: return ELAP_W'($urandom());
    endcase
  endfunction

  function automatic logic [DEN_W-1:0] random_den();
    return {8'($urandom_range(255)), 32'($urandom())};
  endfunction

  // Register value with random garbage above the register's width.
  function automatic logic [DATA_W-1:0] num_word(input logic [NUM_W-1:0] num);
    return {32'($urandom()), num};
  endfunction

  function automatic logic [DATA_W-1:0] den_word(input logic [DEN_W-1:0] den);
    return {24'($urandom_range(24'hFFFFFF)), den};
  endfunction

  initial begin
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    int unsigned      phase;
    int unsigned      idx;

    sb                = new();
    send_idle_pct     = 0;
    stall_pct         = 0;
    stall_burst       = 0;
    cycle_count       = 0;
    ratio_settings    = 0;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_elapsed_clocks <= '0;
    out_ready         <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset ratio 1/4: fraction carries until a whole tick appears.
    send_batch('0);
    send_batch(ELAP_W'(1));
    send_batch(ELAP_W'(1));
    send_batch(ELAP_W'(1));
    send_batch(ELAP_W'(1));
    send_batch(ELAP_W'(3));
    send_batch('1);
    send_batch(ELAP_W'(4));
    in_valid <= 1'b0;

    // Zero numerator (upper bits set) falls back to 1/4.
    drain_results();
    apb_write(REG_NUMERATOR, 64'hFFFF_FFFF_0000_0000);
    send_batch(ELAP_W'(5));
    send_batch(ELAP_W'(3));
    in_valid <= 1'b0;

    // Zero denominator (upper bits set) falls back to 1/4 as well.
    set_ratio('1, 64'hFFFF_FF00_0000_0000);
    send_batch(ELAP_W'(32'h1234_5678));
    send_batch(ELAP_W'(2));
    in_valid <= 1'b0;

    // Largest numerator over denominator one: the largest quotients.
    set_ratio('1, 64'h0000_0000_0000_0001);
    send_batch('1);
    send_batch('0);
    send_batch(ELAP_W'(1));
    in_valid <= 1'b0;

    // Largest numerator and denominator: the fraction grows until the dividend
    // carries into bit 64.
    set_ratio('1, '1);
    repeat (6) send_batch('1);
    in_valid <= 1'b0;

    // Random phases, each with its own ratio and idling pattern.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 7)
        0: begin
          num = NUM_W'(1);
          den = DEN_W'(4);
        end
        1: begin
          num = '1;
          den = DEN_W'(1);
        end
        2: begin
          num = '1;
          den = '1;
        end
        3: begin
          num = NUM_W'($urandom());
          den = random_den();
        end
        4: begin
          num = NUM_W'($urandom_range(16, 1));
          den = DEN_W'($urandom_range(64, 1));
        end
        5: begin
          num = '0;
          den = DEN_W'($urandom_range(1000, 1));
        end
        default: begin
          num = NUM_W'($urandom());
          den = ($urandom_range(1) == 0) ? '0 : DEN_W'($urandom());
        end
      endcase
      set_ratio(num_word(num), den_word(den));
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 69;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 69;
        end
        default: begin
          send_idle_pct = 19;
          stall_pct     = 19;
        end
      endcase
      for (idx = 0; idx < ITEMS_PER_PHASE; idx++) begin
        pace_sender();
        send_batch(pick_elapsed());
      end
      in_valid <= 1'b0;
    end

    // Let the last results come out, then look for stray ones.
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d batches under %0d ratio settings (%0d register writes).",
             sb.batches, ratio_settings + 2, sb.ratio_writes);
    $display("Checked %0d results: %0d without a tick, %0d with a 65-bit dividend.",
             sb.results, sb.idle_batches, sb.wide_dividends);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/fcrc_pkg.sv
design/fractional_clock_ratio_converter.sv
sim/testbench.sv
